FILE: rtl/ifbp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifbp_pkg
// shared types and constants of the intrusion flag block parser
// ----------------------------------------------------------------------------
package ifbp_pkg;

  localparam int unsigned PATH_COUNT = 24;
  localparam int unsigned PATH_W     = 5;
  localparam int unsigned SIZE_W     = 32;
  localparam int unsigned BEAM_W     = 16;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned FCNT_W     = 4;

  localparam logic [FCNT_W-1:0] FLAGS_PER_BYTE = FCNT_W'(BYTE_W);

  localparam logic KIND_SIZE  = 1'b0;
  localparam logic KIND_FLAGS = 1'b1;

  typedef enum logic [1:0] {
    PH_SIZE    = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_DONE    = 2'd2
  } phase_t;

  typedef struct packed {
    logic              record_kind;
    logic [PATH_W-1:0] path_index;
    logic [SIZE_W-1:0] path_size;
    logic [BEAM_W-1:0] first_beam;
    logic [BYTE_W-1:0] flag_bits;
    logic [FCNT_W-1:0] flag_count;
    logic              path_last;
  } result_t;

endpackage

FILE: rtl/intrusion_flag_block_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// intrusion_flag_block_parser
// parses cut-off path sizes and per-byte intrusion flags from a byte stream
// ----------------------------------------------------------------------------
//  channel  | ports                                   | role
//  ---------+-----------------------------------------+--------------------------
//  in       | in_valid, in_stall, in_data_byte,       | one block byte per transfer
//           | in_block_start                          |
//  out      | out_valid, out_stall, out_record_kind,  | size or flag record
//           | out_path_index .. out_path_last         |
//  cfg      | cfg_wr_en, cfg_wr_data                  | beam_count register
//
//  one byte per cycle while in_stall is low; each record is registered in out_r
//  the parse state updates in the same cycle that the byte is taken
//  a two-entry output (result register plus skid) keeps in flowing while out
//  is stalled; in_stall rises only when both entries hold records
//  rst_n is synchronous: the parser restarts in the size phase of path zero
// ----------------------------------------------------------------------------
module intrusion_flag_block_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_block_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_record_kind,
  output logic [4:0]  out_path_index,
  output logic [31:0] out_path_size,
  output logic [15:0] out_first_beam,
  output logic [7:0]  out_flag_bits,
  output logic [3:0]  out_flag_count,
  output logic        out_path_last
);

  ifbp_pkg::phase_t  phase_r, phase_nxt;
  logic [4:0]        path_r, path_nxt;
  logic [1:0]        size_idx_r, size_idx_nxt;
  logic [31:0]       size_acc_r, size_acc_nxt;
  logic [31:0]       remain_r, remain_nxt;
  logic [15:0]       flags_r, flags_nxt;
  logic [15:0]       beam_count_r;

  ifbp_pkg::result_t out_r, out_nxt;
  ifbp_pkg::result_t skid_r, skid_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              skid_valid_r, skid_valid_nxt;

  ifbp_pkg::result_t res;
  logic              res_valid;
  logic              in_fire;
  logic              out_free;

  // state as seen by this byte, after a possible block restart
  ifbp_pkg::phase_t  ph_cur;
  logic [4:0]        path_cur;
  logic [1:0]        idx_cur;
  logic [31:0]       acc_cur;
  logic [31:0]       remain_cur;
  logic [15:0]       flags_cur;

  logic [31:0]       acc_new;
  logic [31:0]       remain_dec;
  logic [16:0]       flags_left;
  logic [3:0]        take_n;
  logic [8:0]        bit_mask;
  logic [16:0]       flags_sum;
  logic [5:0]        path_inc;

  assign in_stall = skid_valid_r;
  assign in_fire  = in_valid && !skid_valid_r;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    ph_cur     = phase_r;
    path_cur   = path_r;
    idx_cur    = size_idx_r;
    acc_cur    = size_acc_r;
    remain_cur = remain_r;
    flags_cur  = flags_r;
    if (in_block_start) begin
      ph_cur     = ifbp_pkg::PH_SIZE;
      path_cur   = '0;
      idx_cur    = '0;
      acc_cur    = '0;
      remain_cur = '0;
      flags_cur  = '0;
    end

    case (idx_cur)
      2'd0:    acc_new = acc_cur | {24'd0, in_data_byte};
      2'd1:    acc_new = acc_cur | {16'd0, in_data_byte, 8'd0};
      2'd2:    acc_new = acc_cur | {8'd0, in_data_byte, 16'd0};
      2'd3:    acc_new = acc_cur | {in_data_byte, 24'd0};
      default: acc_new = acc_cur;
    endcase

    remain_dec = remain_cur - 32'd1;
    flags_left = {1'b0, beam_count_r} - {1'b0, flags_cur};
    take_n     = (flags_left > 17'(ifbp_pkg::FLAGS_PER_BYTE))
                 ? ifbp_pkg::FLAGS_PER_BYTE : flags_left[3:0];
    bit_mask   = (9'd1 << take_n) - 9'd1;
    flags_sum  = {1'b0, flags_cur} + {13'd0, take_n};
    path_inc   = {1'b0, path_cur} + 6'd1;

    phase_nxt    = ph_cur;
    path_nxt     = path_cur;
    size_idx_nxt = idx_cur;
    size_acc_nxt = acc_cur;
    remain_nxt   = remain_cur;
    flags_nxt    = flags_cur;

    res             = '0;
    res.path_index  = path_cur;
    res_valid       = 1'b0;

    case (ph_cur)
      ifbp_pkg::PH_SIZE: begin
        size_acc_nxt = acc_new;
        size_idx_nxt = idx_cur + 2'd1;
        if (idx_cur == 2'd3) begin
          res_valid       = 1'b1;
          res.record_kind = ifbp_pkg::KIND_SIZE;
          res.path_size   = acc_new;
          res.path_last   = (acc_new == '0) || (beam_count_r == '0);
          remain_nxt      = acc_new;
          flags_nxt       = '0;
          phase_nxt       = ifbp_pkg::PH_PAYLOAD;
        end
      end
      ifbp_pkg::PH_PAYLOAD: begin
        remain_nxt = remain_dec;
        if (flags_cur < beam_count_r) begin
          res_valid       = 1'b1;
          res.record_kind = ifbp_pkg::KIND_FLAGS;
          res.first_beam  = flags_cur;
          res.flag_bits   = in_data_byte & bit_mask[7:0];
          res.flag_count  = take_n;
          res.path_last   = (flags_sum[15:0] >= beam_count_r) || (remain_dec == '0);
          flags_nxt       = flags_sum[15:0];
        end
      end
      default: ;
    endcase

    // path ends: empty size or last payload byte
    if ((ph_cur == ifbp_pkg::PH_SIZE && idx_cur == 2'd3 && acc_new == '0) ||
        (ph_cur == ifbp_pkg::PH_PAYLOAD && remain_dec == '0)) begin
      path_nxt = path_inc[4:0];
      if (path_inc >= 6'(ifbp_pkg::PATH_COUNT)) begin
        phase_nxt = ifbp_pkg::PH_DONE;
      end else begin
        phase_nxt    = ifbp_pkg::PH_SIZE;
        size_idx_nxt = '0;
        size_acc_nxt = '0;
      end
    end
  end

  // result register with skid entry
  always_comb begin
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (out_free) begin
      if (skid_valid_r) begin
        out_nxt        = skid_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        out_nxt       = res;
        out_valid_nxt = in_fire && res_valid;
      end
    end else if (in_fire && res_valid) begin
      skid_nxt       = res;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= ifbp_pkg::PH_SIZE;
      path_r       <= '0;
      size_idx_r   <= '0;
      size_acc_r   <= '0;
      remain_r     <= '0;
      flags_r      <= '0;
      beam_count_r <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_r    <= phase_nxt;
        path_r     <= path_nxt;
        size_idx_r <= size_idx_nxt;
        size_acc_r <= size_acc_nxt;
        remain_r   <= remain_nxt;
        flags_r    <= flags_nxt;
      end
      if (cfg_wr_en) begin
        beam_count_r <= cfg_wr_data;
      end
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_record_kind = out_r.record_kind;
  assign out_path_index  = out_r.path_index;
  assign out_path_size   = out_r.path_size;
  assign out_first_beam  = out_r.first_beam;
  assign out_flag_bits   = out_r.flag_bits;
  assign out_flag_count  = out_r.flag_count;
  assign out_path_last   = out_r.path_last;

endmodule

FILE: rtl/ifbp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifbp_checker
// port-level checks of the intrusion flag block parser
// ----------------------------------------------------------------------------
module ifbp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        cfg_wr_en,
  input logic [15:0] cfg_wr_data,
  input logic        in_valid,
  input logic        in_stall,
  input logic [7:0]  in_data_byte,
  input logic        in_block_start,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_record_kind,
  input logic [4:0]  out_path_index,
  input logic [31:0] out_path_size,
  input logic [15:0] out_first_beam,
  input logic [7:0]  out_flag_bits,
  input logic [3:0]  out_flag_count,
  input logic        out_path_last
);

  // nothing comes out in the cycle after reset
  a_quiet_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high right after reset");

  // a stalled record holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_path_index)
      && $stable(out_record_kind) && $stable(out_flag_bits))
    else $error("stalled record changed");

  a_size_record_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_record_kind == ifbp_pkg::KIND_SIZE |->
      out_flag_count == '0 && out_flag_bits == '0 && out_first_beam == '0)
    else $error("size record carries flag data");

  // flag records carry a nonzero count of at most FLAGS_PER_BYTE, no path size, and no flag bits above the count
  a_flag_record_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_record_kind == ifbp_pkg::KIND_FLAGS |->
      out_flag_count != '0 && out_flag_count <= ifbp_pkg::FLAGS_PER_BYTE
      && (({1'b0, out_flag_bits} >> out_flag_count) == 9'd0) && out_path_size == '0)
    else $error("bad flag record");

  a_path_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_path_index < 5'(ifbp_pkg::PATH_COUNT))
    else $error("path index out of range");

endmodule

bind intrusion_flag_block_parser ifbp_checker u_ifbp_checker (.*);

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the intrusion flag block parser: a local parse
// model predicts every size and flag record from the accepted bytes, and a
// monitor compares each record taken from the output against the oldest
// prediction, under random idling, stalls and a long receiver hold-off
// ----------------------------------------------------------------------------
module tb_top;

  localparam int DRAIN_CYCLES = 4;
  localparam int IDLE_PCT     = 38;
  localparam int RANDOM_BYTES = 1200;
  localparam int HOLD_CYCLES  = 250;

  logic        clk            = 1'b0;
  logic        rst_n          = 1'b0;
  logic        cfg_wr_en      = 1'b0;
  logic [15:0] cfg_wr_data    = '0;
  logic        in_valid       = 1'b0;
  logic [7:0]  in_data_byte   = '0;
  logic        in_block_start = 1'b0;
  logic        out_stall      = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic        out_record_kind;
  logic [4:0]  out_path_index;
  logic [31:0] out_path_size;
  logic [15:0] out_first_beam;
  logic [7:0]  out_flag_bits;
  logic [3:0]  out_flag_count;
  logic        out_path_last;

  always #2 clk = ~clk;

  intrusion_flag_block_parser u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_byte   (in_data_byte),
    .in_block_start (in_block_start),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_record_kind(out_record_kind),
    .out_path_index (out_path_index),
    .out_path_size  (out_path_size),
    .out_first_beam (out_first_beam),
    .out_flag_bits  (out_flag_bits),
    .out_flag_count (out_flag_count),
    .out_path_last  (out_path_last)
  );

  // parse model state
  ifbp_pkg::phase_t ph    = ifbp_pkg::PH_SIZE;
  logic [4:0]  cur_path   = '0;
  logic [1:0]  size_idx   = '0;
  logic [31:0] size_acc   = '0;
  logic [31:0] bytes_left = '0;
  logic [15:0] flags_done = '0;
  logic [15:0] beams      = '0;

  ifbp_pkg::result_t pending_records[$];
  int      mismatches = 0;
  int      bytes_sent = 0;
  bit      no_idle    = 1'b0;
  bit      hold_req   = 1'b0;
  int      hold_left  = 0;

  function automatic void start_size();
    ph       = ifbp_pkg::PH_SIZE;
    size_idx = '0;
    size_acc = '0;
  endfunction

  function automatic void advance_path();
    logic [5:0] nxt;
    nxt = {1'b0, cur_path} + 6'd1;
    if (nxt >= 6'(ifbp_pkg::PATH_COUNT)) begin
      ph       = ifbp_pkg::PH_DONE;
      cur_path = nxt[4:0];
    end else begin
      cur_path = nxt[4:0];
      start_size();
    end
  endfunction

  function automatic bit predict_record(input logic [7:0] b, input logic start,
                                        output ifbp_pkg::result_t rec);
    logic [15:0] room;
    logic [3:0]  n;
    bit          got;
    rec = '0;
    got = 1'b0;
    if (start) begin
      cur_path   = '0;
      flags_done = '0;
      bytes_left = '0;
      start_size();
    end
    case (ph)
      ifbp_pkg::PH_SIZE: begin
        size_acc = size_acc | (32'(b) << (8 * size_idx));
        size_idx = size_idx + 2'd1;
        if (size_idx == 2'd0) begin
          rec.record_kind = ifbp_pkg::KIND_SIZE;
          rec.path_index  = cur_path;
          rec.path_size   = size_acc;
          rec.path_last   = (size_acc == 0) || (beams == 0);
          bytes_left      = size_acc;
          flags_done      = '0;
          got             = 1'b1;
          if (bytes_left == 0) advance_path();
          else ph = ifbp_pkg::PH_PAYLOAD;
        end
      end
      ifbp_pkg::PH_PAYLOAD: begin
        bytes_left = bytes_left - 32'd1;
        if (flags_done < beams) begin
          room            = beams - flags_done;
          n               = (room > 16'(ifbp_pkg::FLAGS_PER_BYTE))
                            ? ifbp_pkg::FLAGS_PER_BYTE : room[3:0];
          rec.record_kind = ifbp_pkg::KIND_FLAGS;
          rec.path_index  = cur_path;
          rec.first_beam  = flags_done;
          rec.flag_bits   = b & 8'((9'd1 << n) - 9'd1);
          rec.flag_count  = n;
          flags_done      = flags_done + 16'(n);
          rec.path_last   = (flags_done >= beams) || (bytes_left == 0);
          got             = 1'b1;
        end
        if (bytes_left == 0) advance_path();
      end
      default: ;
    endcase
    return got;
  endfunction

  function automatic void match_field(string fname, logic [31:0] want, logic [31:0] seen);
    if (seen !== want) begin
      $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, fname, want, seen);
      mismatches++;
    end
  endfunction

  // output monitor
  always @(posedge clk) begin : check_out
    ifbp_pkg::result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_records.size() == 0) begin
        $display("%0t ns: unexpected record, expected none actual kind %0d path %0d",
                 $time, out_record_kind, out_path_index);
        mismatches++;
      end else begin
        want = pending_records.pop_front();
        match_field("record_kind", 32'(want.record_kind), 32'(out_record_kind));
        match_field("path_index", 32'(want.path_index), 32'(out_path_index));
        match_field("path_size", want.path_size, out_path_size);
        match_field("first_beam", 32'(want.first_beam), 32'(out_first_beam));
        match_field("flag_bits", 32'(want.flag_bits), 32'(out_flag_bits));
        match_field("flag_count", 32'(want.flag_count), 32'(out_flag_count));
        match_field("path_last", 32'(want.path_last), 32'(out_path_last));
      end
    end
  end

  // receiver: random stalls, or a counted hold-off when requested
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= !no_idle && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic start);
    ifbp_pkg::result_t rec;
    while (!no_idle && ($urandom_range(0, 99) < IDLE_PCT)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_data_byte   <= b;
    in_block_start <= start;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
    if (predict_record(b, start, rec)) pending_records = {pending_records, rec};
  endtask

  task automatic send_path(input logic [31:0] size, input int body_len, input logic start);
    for (int k = 0; k < 4; k++) send_byte(size[8*k +: 8], start && (k == 0));
    for (int k = 0; k < body_len; k++) send_byte(8'($urandom), 1'b0);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_records.size() != 0) @(posedge clk);
    // bytes that cause no record may still be in flight
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_beams(input logic [15:0] v);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    beams = v;
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [15:0] pick_beams();
    case ($urandom_range(0, 9))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'(ifbp_pkg::FLAGS_PER_BYTE);
      3:       return 16'($urandom_range(1, 7));
      4, 5:    return 16'($urandom_range(9, 24));
      6, 7:    return 16'($urandom_range(25, 120));
      8:       return 16'($urandom_range(0, 65535));
      default: return 16'd1;
    endcase
  endfunction

  function automatic logic [31:0] pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 32'd0;
    if (r < 75) return 32'($urandom_range(1, 12));
    if (r < 95) return 32'($urandom_range(13, 40));
    return 32'($urandom_range(41, 300));
  endfunction

  // beam count is zero after reset: sizes only, payload is skipped
  task automatic test_no_beams();
    send_path(32'd2, 0, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_path(32'd0, 0, 1'b0);
  endtask

  // flags run out inside a path, and a payload that ends before the limit
  task automatic test_flag_limits();
    write_beams(16'd12);
    send_path(32'd3, 0, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h00, 1'b0);
    send_path(32'd1, 0, 1'b0);
    send_byte(8'h81, 1'b0);
    write_beams(16'hFFFF);
    send_path(32'd2, 0, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h7E, 1'b0);
  endtask

  // full 32-bit size, abandoned by a new block start
  task automatic test_huge_size();
    write_beams(16'd20);
    send_path(32'hFFFF_FFFF, 3, 1'b1);
    send_path(32'd0, 0, 1'b1);
  endtask

  // new beam count in the middle of a path resumes flag taking
  task automatic test_midpath_config();
    write_beams(16'd9);
    send_path(32'd4, 2, 1'b1);
    write_beams(16'd20);
    send_byte(8'h5A, 1'b0);
    send_byte(8'hC3, 1'b0);
  endtask

  task automatic test_back_to_back();
    write_beams(16'd13);
    wait_idle();
    no_idle = 1'b1;
    for (int p = 0; p < 6; p++) begin
      logic [31:0] sz;
      sz = pick_size();
      send_path(sz, int'(sz), p == 0);
    end
    wait_idle();
    no_idle = 1'b0;
  endtask

  // receiver holds off while every payload byte yields a record, so input must stall
  task automatic test_output_backpressure();
    write_beams(16'hFFFF);
    hold_req = 1'b1;
    send_path(32'd150, 150, 1'b1);
  endtask

  task automatic test_random_blocks();
    int target;
    int n;
    logic [31:0] sz;
    target = bytes_sent + RANDOM_BYTES;
    while (bytes_sent < target) begin
      write_beams(pick_beams());
      n = $urandom_range(0, 99);
      if (n < 75) begin
        for (int p = 0; p < int'(ifbp_pkg::PATH_COUNT); p++) begin
          if ($urandom_range(0, 15) == 0) write_beams(pick_beams());
          sz = pick_size();
          send_path(sz, int'(sz), p == 0);
        end
        // bytes past the last path are ignored
        repeat ($urandom_range(0, 6)) send_byte(8'($urandom), 1'b0);
      end else if (n < 88) begin
        n = $urandom_range(1, int'(ifbp_pkg::PATH_COUNT) - 1);
        for (int p = 0; p < n; p++) begin
          sz = pick_size();
          send_path(sz, int'(sz), p == 0);
        end
        case ($urandom_range(0, 2))
          0: repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0);
          1: begin
            sz = pick_size();
            send_path(sz, $urandom_range(0, int'(sz)), 1'b0);
          end
          default: send_path($urandom | 32'h0100_0000, $urandom_range(0, 10), 1'b0);
        endcase
      end else begin
        repeat ($urandom_range(10, 40))
          send_byte(8'($urandom), $urandom_range(0, 7) == 0);
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_no_beams();
    test_flag_limits();
    test_huge_size();
    test_midpath_config();
    test_back_to_back();
    test_output_backpressure();
    test_random_blocks();
    wait_idle();
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
